### hdl/idf2_pkg.sv
package idf2_pkg;

    // Filter configuration
    localparam int ORDER          = 2;
    localparam int COEF_FRAC_BITS = 14;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int DELAY_W  = 32;
    localparam int PDATA_W  = 32;

    localparam int NUM_COEFS = 2 * ORDER + 1;
    localparam int PADDR_W   = $clog2(4 * NUM_COEFS);
    localparam int IDX_W     = PADDR_W - 2;
    localparam int DSEL_W    = $clog2(ORDER + 1);
    localparam int PROD_W    = COEF_W + DELAY_W;
    localparam int ACC_W     = PROD_W + $clog2(ORDER + 1) + 1;

    // Microprogram layout
    localparam int FF_BASE   = ORDER + 3;           // first feedforward fetch
    localparam int LAST_STEP = FF_BASE + ORDER + 3; // output step
    localparam int STEPS     = LAST_STEP + 1;
    localparam int STEP_W    = $clog2(STEPS);

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] W_MAX    = (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] W_MIN    = -(ACC_W'(1) <<< (DELAY_W - 1));
    localparam logic signed [ACC_W-1:0] Y_MAX    = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN    = -(ACC_W'(1) <<< (SAMPLE_W - 1));

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_SUB  = 2'd1,
        ACC_LOAD = 2'd2,
        ACC_ADD  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT     = 2'd0,
        SEQ_WAIT_IN  = 2'd1,
        SEQ_WAIT_OUT = 2'd2
    } seq_cond_t;

    typedef struct packed {
        logic [IDX_W-1:0]  coef_sel;
        logic [DSEL_W-1:0] data_sel;   // 0: w0, k: delay tap k
        logic              mul_en;
        acc_op_t           acc_op;
        logic              w0_load;
        seq_cond_t         cond;
    } ctrl_t;

    // Program ROM: one control word per step.
    // Fetch, multiply and accumulate run in successive steps.
    function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
        int unsigned s;
        ctrl_t       c;
        s          = step;
        c.coef_sel = '0;
        c.data_sel = '0;
        c.mul_en   = 1'b0;
        c.acc_op   = ACC_HOLD;
        c.w0_load  = 1'b0;
        c.cond     = SEQ_NEXT;
        // feedback: acc = x<<F - sum a_k*w_k
        if (s < ORDER)
        begin
            c.coef_sel = IDX_W'(ORDER + 1 + s);
            c.data_sel = DSEL_W'(s + 1);
        end
        if (s >= 1 && s <= ORDER)
            c.mul_en = 1'b1;
        if (s >= 2 && s <= ORDER + 1)
            c.acc_op = ACC_SUB;
        if (s == ORDER + 2)
            c.w0_load = 1'b1;
        // feedforward: acc = b0*w0 + sum b_k*w_k
        if (s >= FF_BASE && s <= FF_BASE + ORDER)
        begin
            c.coef_sel = IDX_W'(s - FF_BASE);
            c.data_sel = DSEL_W'(s - FF_BASE);
        end
        if (s >= FF_BASE + 1 && s <= FF_BASE + ORDER + 1)
            c.mul_en = 1'b1;
        if (s == FF_BASE + 2)
            c.acc_op = ACC_LOAD;
        if (s >= FF_BASE + 3 && s <= FF_BASE + ORDER + 2)
            c.acc_op = ACC_ADD;
        if (s == 0)
            c.cond = SEQ_WAIT_IN;
        if (s == LAST_STEP)
            c.cond = SEQ_WAIT_OUT;
        return c;
    endfunction

    // Round half up by F bits, then clamp to [lo, hi].
    function automatic logic signed [ACC_W-1:0] sat_round(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] r;
        r = (a + ACC_HALF) >>> COEF_FRAC_BITS;
        if (r < lo)
            return lo;
        if (r > hi)
            return hi;
        return r;
    endfunction

endpackage

### hdl/idf2_mac.sv
module idf2_mac (
    input  logic                                 clk,
    input  logic                                 mul_en,
    input  idf2_pkg::acc_op_t                    acc_op,
    input  logic                                 acc_init,
    input  logic signed [idf2_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [idf2_pkg::COEF_W-1:0]   coef_q,
    input  logic signed [idf2_pkg::DELAY_W-1:0]  data_q,
    output logic signed [idf2_pkg::ACC_W-1:0]    acc
);
    import idf2_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_next = coef_q * data_q;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (acc_init)
            acc_next = ACC_W'(sample) <<< COEF_FRAC_BITS;
        else
        begin
            unique case (acc_op)
                ACC_HOLD: acc_next = acc_reg;
                ACC_SUB:  acc_next = acc_reg - prod_ext;
                ACC_LOAD: acc_next = prod_ext;
                ACC_ADD:  acc_next = acc_reg + prod_ext;
                default:  acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

### hdl/iir_direct_form_two.sv
// Direct form II IIR filter, one signed 16-bit sample per transaction.
//
// Input channel: audio_sample with in_valid/in_ready. in_ready is high only
// while the sequencer sits in its wait step; one sample is worked at a time.
// Output channel: filtered_sample with out_valid/out_ready, held in an output
// register until taken.
// Coefficients (b0..bN, a1..aN, Q3.14, 18 bits) are written over the APB
// port at byte address 4*i; pready is tied high, reads return the value
// sign-extended to 32 bits. Write them only while the filter is idle.
//
// The microprogram walks the single shared 18x32 multiplier through all
// 2*ORDER+1 products, plus fetch, rounding and output steps; a new sample
// is taken only after the previous result has left the output step.
// If the receiver stalls, the sequencer parks in its output step and no new
// sample is taken until the waiting result has been moved.
// Reset: coefficients go to b0 = 1.0 and all others 0 (pass-through), the
// delay line clears, the sequencer returns to its wait step.
module iir_direct_form_two (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [idf2_pkg::PADDR_W-1:0]         paddr,
    input  logic [idf2_pkg::PDATA_W-1:0]         pwdata,
    output logic [idf2_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic signed [idf2_pkg::SAMPLE_W-1:0] audio_sample,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    output logic signed [idf2_pkg::SAMPLE_W-1:0] filtered_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready
);
    import idf2_pkg::*;

    // Sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             ctrl;

    // Coefficient store, operand registers
    logic signed [COEF_W-1:0]  coef_mem [NUM_COEFS];
    logic signed [COEF_W-1:0]  coef_q_reg;
    logic signed [DELAY_W-1:0] data_q_reg, data_q_next;
    logic [PDATA_W-1:0]        prdata_reg;
    logic [IDX_W-1:0]          cfg_idx;
    logic                      cfg_in_range;
    logic                      cfg_wr;

    // Delay line and w0
    logic signed [DELAY_W-1:0] delay_reg [ORDER];
    logic signed [DELAY_W-1:0] w0_reg;

    // Accumulator results
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    w0_full, y_full;
    logic                       in_take;
    logic                       out_write;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] filtered_sample_reg;

    assign ctrl      = prog_word(step_reg);
    assign in_take   = in_valid && in_ready;
    assign in_ready  = (ctrl.cond == SEQ_WAIT_IN);
    assign out_write = (ctrl.cond == SEQ_WAIT_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.cond)
            SEQ_NEXT:     step_next = step_reg + STEP_W'(1);
            SEQ_WAIT_IN:  step_next = in_valid ? step_reg + STEP_W'(1) : step_reg;
            SEQ_WAIT_OUT: step_next = out_write ? '0 : step_reg;
            default:      step_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    // APB register file
    assign cfg_idx      = paddr[PADDR_W-1:2];
    assign cfg_in_range = ({1'b0, cfg_idx} < (IDX_W + 1)'(NUM_COEFS));
    assign cfg_wr       = psel && penable && pwrite && cfg_in_range;
    assign pready       = 1'b1;
    assign prdata       = prdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coef_mem[i] <= (i == 0) ? COEF_ONE : '0;
        end
        else if (cfg_wr)
            coef_mem[cfg_idx] <= pwdata[COEF_W-1:0];
    end

    // prdata is fetched in the setup cycle, valid in the access cycle
    always_ff @(posedge clk)
    begin
        if (cfg_in_range)
            prdata_reg <= PDATA_W'(coef_mem[cfg_idx]);
        else
            prdata_reg <= '0;
        coef_q_reg <= coef_mem[ctrl.coef_sel];
        data_q_reg <= data_q_next;
    end

    always_comb
    begin
        data_q_next = w0_reg;
        for (int k = 0; k < ORDER; k++)
        begin
            if (ctrl.data_sel == DSEL_W'(k + 1))
                data_q_next = delay_reg[k];
        end
    end

    idf2_mac u_mac (
        .clk      (clk),
        .mul_en   (ctrl.mul_en),
        .acc_op   (ctrl.acc_op),
        .acc_init (in_take),
        .sample   (audio_sample),
        .coef_q   (coef_q_reg),
        .data_q   (data_q_reg),
        .acc      (acc)
    );

    assign w0_full = sat_round(acc, W_MIN, W_MAX);
    assign y_full  = sat_round(acc, Y_MIN, Y_MAX);

    always_ff @(posedge clk)
    begin
        if (ctrl.w0_load)
            w0_reg <= w0_full[DELAY_W-1:0];
        if (out_write)
            filtered_sample_reg <= y_full[SAMPLE_W-1:0];
    end

    // Delay line shifts once the output has been formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER; k++)
                delay_reg[k] <= '0;
        end
        else if (out_write)
        begin
            for (int k = ORDER - 1; k > 0; k--)
                delay_reg[k] <= delay_reg[k-1];
            delay_reg[0] <= w0_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_write)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = filtered_sample_reg;

endmodule
